### rtl/fva_pkg.sv
`default_nettype none
package fva_pkg;
  localparam int NUM_JOINTS = 4;
  localparam int JW = $clog2(NUM_JOINTS);
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam int ALPHA_BITS = 30;

  localparam logic [0:0] CFG_TAU = 1'b0;
  localparam logic [0:0] CFG_BYPASS = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef word_t [NUM_JOINTS-1:0] joint_vec_t;

  typedef struct packed {
    logic start_req;
    logic [31:0] time_us;
    joint_vec_t pos;
  } in_item_t;

  typedef struct packed {
    joint_vec_t vel;
    joint_vec_t acc;
    logic last;
    logic interval_error;
  } out_item_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return -32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### rtl/fva_if.sv
`default_nettype none
interface fva_in_if import fva_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fva_out_if import fva_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/fva_div.sv
`default_nettype none
// Restoring divider: 64-bit unsigned numerator by 33-bit divisor, one bit a cycle.
module fva_div
  import fva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;
  logic [33:0] shifted;

  assign shifted = {rem_r[32:0], quo_r[63]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo = quo_nxt;
endmodule
`default_nettype wire

### rtl/filtered_velocity_acceleration_core.sv
`default_nettype none
// Filtered velocity and acceleration of four joints from timestamped position
// samples. One item is taken at a time; in_ready is low while it is worked on.
// A start item or a zero interval needs no division; the second sample of a
// series needs 4 divisions, a normal sample 9 divisions plus the multiply
// steps for each joint, or 8 divisions with the filter bypassed. The time is
// set by the single bit-serial 64/33 divider that computes each rate and the
// filter gain in turn, and by one 32x32 multiplier shared across joints.
// Results wait in an output register until taken.
module filtered_velocity_acceleration_core
  import fva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  fva_in_if.sink           in_ch,
  fva_out_if.source        out_ch
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DECIDE= 7'b0000010,
    S_RAW   = 7'b0000100,
    S_ALPHA = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r;
  logic [23:0] tau_r;
  logic        bypass_r;
  logic [31:0] prev_time_r;
  joint_vec_t  prev_pos_r, filt_r, raw_r, vel_r, acc_r;
  logic [1:0]  seen_r;
  in_item_t    item_r;
  logic [31:0] dt_r;
  logic [31:0] alpha_r;
  logic [JW-1:0] j_r;
  logic        phase_r;       // divider in flight
  logic        neg_r;
  logic [63:0] prod_r;
  logic [1:0]  mstep_r;
  logic        two_r;         // second row pending
  out_item_t   out_r;
  logic        out_valid_r;

  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;
  logic signed [33:0] diff;
  logic [33:0] mag;
  logic signed [63:0] rate_s;
  logic [JW-1:0] jidx;

  assign jidx = j_r;

  fva_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quo(div_quo)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // signed difference feeding the current rate division
  always_comb begin
    if (state_r == S_ACC)
      diff = 34'(vel_r[jidx]) - 34'(filt_r[jidx]);
    else
      diff = 34'(item_r.pos[jidx]) - 34'(prev_pos_r[jidx]);
    mag = diff[33] ? 34'(-diff) : 34'(diff);
  end

  logic [63:0] q_lim;
  always_comb begin
    q_lim  = div_quo;
    rate_s = (q_lim[63:32] != 0) ? 64'sh7FFFFFFFFFFFFFFF : 64'($signed({1'b0, q_lim[62:0]}));
    if (neg_r) rate_s = -rate_s;
  end

  logic [63:0] mag_prod;
  assign mag_prod = mag * 64'(US_PER_S);

  always_comb begin
    div_start = 1'b0;
    div_num   = mag_prod;
    div_den   = {1'b0, dt_r};
    if (state_r == S_ALPHA) begin
      div_num = {dt_r, 32'd0} >> 2;
      div_den = 33'(tau_r) + 33'(dt_r);
    end
    if ((state_r == S_RAW || state_r == S_ALPHA || state_r == S_ACC) && !phase_r)
      div_start = 1'b1;
  end

  // filter step: filt plus or minus (|raw - filt| * alpha) >> ALPHA_BITS
  logic signed [33:0] fd;
  logic [32:0] fmag;
  logic        fneg;
  logic [63:0] fstep;
  logic signed [63:0] ynew;
  always_comb begin
    fd    = 34'(raw_r[jidx]) - 34'(filt_r[jidx]);
    fneg  = fd[33];
    fmag  = fneg ? 33'(-fd) : 33'(fd);
    fstep = prod_r >> ALPHA_BITS;
    ynew  = 64'(filt_r[jidx]) + (fneg ? -$signed(fstep) : $signed(fstep));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tau_r       <= 24'd63662;
      bypass_r    <= 1'b0;
      prev_time_r <= '0;
      prev_pos_r  <= '0;
      filt_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      two_r       <= 1'b0;
      j_r         <= '0;
      mstep_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TAU:    tau_r    <= cfg_data;
          CFG_BYPASS: bypass_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) begin
        if (two_r) begin
          two_r      <= 1'b0;
          out_r.last <= 1'b1;
        end else
          out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r  <= in_ch.data;
            dt_r    <= in_ch.data.time_us - prev_time_r;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          j_r     <= '0;
          phase_r <= 1'b0;
          if (item_r.start_req || seen_r == 2'd0) begin
            prev_time_r <= item_r.time_us;
            prev_pos_r  <= item_r.pos;
            filt_r      <= '0;
            seen_r      <= 2'd1;
            state_r     <= S_IDLE;
          end else if (dt_r == 0) begin
            out_r.vel <= filt_r;
            out_r.acc <= '0;
            out_r.last <= 1'b1;
            out_r.interval_error <= 1'b1;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else
            state_r <= S_RAW;
        end
        S_RAW: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            neg_r   <= diff[33];
          end else if (div_done) begin
            phase_r <= 1'b0;
            raw_r[jidx] <= sat32(rate_s);
            if (j_r == JW'(NUM_JOINTS - 1)) begin
              j_r <= '0;
              if (seen_r == 2'd1) begin
                state_r <= S_OUT;
              end else if (bypass_r)
                state_r <= S_MUL;
              else
                state_r <= S_ALPHA;
            end else
              j_r <= j_r + JW'(1);
          end
        end
        S_ALPHA: begin
          if (!phase_r) phase_r <= 1'b1;
          else if (div_done) begin
            phase_r <= 1'b0;
            alpha_r <= div_quo[31:0];
            mstep_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (bypass_r) begin
            vel_r[jidx] <= raw_r[jidx];
          end else begin
            unique case (mstep_r)
              2'd0: prod_r <= 64'(fmag[31:0]) * 64'(alpha_r);
              2'd1: if (fmag[32]) prod_r <= prod_r + {alpha_r, 32'd0};
              2'd2: ;
              default: vel_r[jidx] <= sat32(ynew);
            endcase
          end
          if (bypass_r || mstep_r == 2'd3) begin
            mstep_r <= '0;
            if (j_r == JW'(NUM_JOINTS - 1)) begin
              j_r <= '0;
              state_r <= S_ACC;
            end else
              j_r <= j_r + JW'(1);
          end else
            mstep_r <= mstep_r + 2'd1;
        end
        S_ACC: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            neg_r   <= diff[33];
          end else if (div_done) begin
            phase_r <= 1'b0;
            acc_r[jidx] <= sat32(rate_s);
            if (j_r == JW'(NUM_JOINTS - 1)) begin
              j_r <= '0;
              state_r <= S_OUT;
            end else
              j_r <= j_r + JW'(1);
          end
        end
        S_OUT: begin
          out_r.interval_error <= 1'b0;
          prev_time_r <= item_r.time_us;
          prev_pos_r  <= item_r.pos;
          out_valid_r <= 1'b1;
          if (seen_r == 2'd1) begin
            out_r.vel  <= raw_r;
            out_r.acc  <= '0;
            out_r.last <= 1'b0;
            filt_r     <= raw_r;
            two_r      <= 1'b1;
            seen_r     <= 2'd2;
          end else begin
            out_r.vel  <= vel_r;
            out_r.acc  <= acc_r;
            out_r.last <= 1'b1;
            filt_r     <= vel_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.interval_error) |-> out_ch.data.last)
    else $error("error without last");
`endif
endmodule
`default_nettype wire
